FILE: design/altpid_pkg.sv
// Shared types and constants for the altitude PID / PWM controller.
package altpid_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_TARGET     = 3'd0;
  localparam logic [2:0] REG_STEP_TIME  = 3'd1;
  localparam logic [2:0] REG_GAIN_PROP  = 3'd2;
  localparam logic [2:0] REG_GAIN_INTEG = 3'd3;
  localparam logic [2:0] REG_GAIN_DERIV = 3'd4;
  localparam logic [2:0] REG_INIT_BASE  = 3'd5;
  localparam logic [2:0] REG_LEVEL_MIN  = 3'd6;
  localparam logic [2:0] REG_LEVEL_MAX  = 3'd7;

  // Register reset values
  localparam logic [23:0] RST_TARGET     = 24'd78643;
  localparam logic [15:0] RST_STEP_TIME  = 16'd6554;
  localparam logic [31:0] RST_GAIN_PROP  = 32'd1649267;
  localparam logic [31:0] RST_GAIN_INTEG = 32'd32985;
  localparam logic [31:0] RST_GAIN_DERIV = 32'd9895605;
  localparam logic [31:0] RST_INIT_BASE  = 32'd764857985;
  localparam logic [31:0] RST_LEVEL_MIN  = 32'd0;
  localparam logic [31:0] RST_LEVEL_MAX  = 32'd2147483648;

  // Error thresholds (Q9.16) and integral clamp (Q1.16)
  localparam logic signed [24:0] STABLE_LIM  = 25'sd3276;
  localparam logic signed [24:0] INTEG_LIM   = 25'sd13107;
  localparam logic signed [17:0] INTEG_CLAMP = 18'sd6554;

  // Operand selection of the shared multiplier
  localparam logic [1:0] MUL_DT = 2'd0;
  localparam logic [1:0] MUL_P  = 2'd1;
  localparam logic [1:0] MUL_I  = 2'd2;
  localparam logic [1:0] MUL_D  = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;       // take the height request, form the error
    logic       mul_en;     // register a product
    logic [1:0] mul_sel;    // multiplier operand pair
    logic       integ_upd;  // update the integral from the product
    logic       acc_load;   // accumulator takes the product
    logic       acc_add;    // accumulator adds the product
    logic       rnd;        // round the accumulator to Q0.32
    logic       fin;        // add base, clamp, load the output register
  } dp_cmd_t;

endpackage

FILE: design/altpid_ctrl.sv
// Sequencing state machine of the altitude PID controller.
module altpid_ctrl
  import altpid_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MDT  = 3'd1;
  localparam logic [2:0] ST_MP   = 3'd2;
  localparam logic [2:0] ST_MI   = 3'd3;
  localparam logic [2:0] ST_MD   = 3'd4;
  localparam logic [2:0] ST_SUM  = 3'd5;
  localparam logic [2:0] ST_RND  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  // no request is taken while reset is held
  assign in_ready = (state == ST_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_sel = MUL_DT;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = ST_MDT;
        end
      end
      ST_MDT: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_DT;
        state_next = ST_MP;
      end
      ST_MP: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_P;
        state_next = ST_MI;
      end
      ST_MI: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_I;
        state_next = ST_MD;
      end
      ST_MD: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_D;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.acc_add = 1'b1;
        state_next = ST_RND;
      end
      ST_RND: begin
        cmd.rnd = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // wait until the output register is free
        if (out_free) begin
          cmd.fin = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/altpid_dp.sv
// Datapath of the altitude PID controller: registers, shared multiplier, accumulator.
module altpid_dp
  import altpid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [23:0] height,
  output logic [31:0]        pwm_level,
  output logic               base_adapted
);

  // Configuration registers
  logic signed [23:0] setpoint;
  logic [15:0]        step_time;
  logic [31:0]        gain_prop;
  logic [31:0]        gain_integ;
  logic [31:0]        gain_deriv;
  logic [31:0]        level_min;
  logic [31:0]        level_max;

  // Controller state
  logic signed [24:0] last_error;
  logic signed [13:0] integral_sum;
  logic [31:0]        base_level;
  logic [31:0]        last_level;

  // Per-request working registers
  logic signed [24:0] err_r;
  logic signed [25:0] diff_r;
  logic               integ_en;
  logic               adapted;
  logic signed [58:0] prod;
  logic signed [59:0] acc;
  logic signed [35:0] rnd_r;

  // Combinational signals
  logic signed [24:0] err;
  logic signed [25:0] diff;
  logic               err_small;
  logic               last_small;
  logic               err_integ;
  logic signed [25:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [32:0] p_rnd;
  logic signed [16:0] inc;
  logic signed [17:0] integ_sum;
  logic signed [13:0] integ_next;
  logic signed [59:0] acc_rnd;
  logic signed [37:0] level;
  logic signed [37:0] max_e;
  logic signed [37:0] min_e;
  logic signed [37:0] lvl_hi;
  logic signed [37:0] lvl_lo;

  // Error, error difference and threshold tests
  assign err = {setpoint[23], setpoint} - {height[23], height};
  assign diff = {err[24], err} - {last_error[24], last_error};
  assign err_small = (err >= -STABLE_LIM) && (err <= STABLE_LIM);
  assign last_small = (last_error >= -STABLE_LIM) && (last_error <= STABLE_LIM);
  assign err_integ = (err >= -INTEG_LIM) && (err <= INTEG_LIM);

  // Multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_DT: begin
        mul_a = {err_r[24], err_r};
        mul_b = {17'd0, step_time};
      end
      MUL_P: begin
        mul_a = {err_r[24], err_r};
        mul_b = {1'b0, gain_prop};
      end
      MUL_I: begin
        mul_a = {{12{integral_sum[13]}}, integral_sum};
        mul_b = {1'b0, gain_integ};
      end
      MUL_D: begin
        mul_a = diff_r;
        mul_b = {1'b0, gain_deriv};
      end
    endcase
  end

  // Integral: round err*dt to Q.16, add, clamp; 0 past INTEG_LIM, else err*dt < 2^30
  always_comb begin
    p_rnd = {prod[31], prod[31:0]} + 33'sd32768;
    inc = p_rnd[32:16];
    integ_sum = {{4{integral_sum[13]}}, integral_sum} + {inc[16], inc};
    if (!integ_en) begin
      integ_next = '0;
    end else if (integ_sum > INTEG_CLAMP) begin
      integ_next = INTEG_CLAMP[13:0];
    end else if (integ_sum < -INTEG_CLAMP) begin
      integ_next = 14'(-INTEG_CLAMP);
    end else begin
      integ_next = integ_sum[13:0];
    end
  end

  // Rounding of the Q.56 sum and final level with clamps
  always_comb begin
    acc_rnd = acc + 60'sd8388608;
    level = {6'd0, base_level} + {{2{rnd_r[35]}}, rnd_r};
    max_e = {6'd0, level_max};
    min_e = {6'd0, level_min};
    lvl_hi = (level > max_e) ? max_e : level;
    lvl_lo = (lvl_hi < min_e) ? min_e : lvl_hi;
  end

  // Configuration and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= RST_TARGET;
      step_time <= RST_STEP_TIME;
      gain_prop <= RST_GAIN_PROP;
      gain_integ <= RST_GAIN_INTEG;
      gain_deriv <= RST_GAIN_DERIV;
      level_min <= RST_LEVEL_MIN;
      level_max <= RST_LEVEL_MAX;
      last_error <= '0;
      integral_sum <= '0;
      base_level <= RST_INIT_BASE;
      last_level <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TARGET:     setpoint <= cfg_data[23:0];
          REG_STEP_TIME:  step_time <= cfg_data[15:0];
          REG_GAIN_PROP:  gain_prop <= cfg_data;
          REG_GAIN_INTEG: gain_integ <= cfg_data;
          REG_GAIN_DERIV: gain_deriv <= cfg_data;
          // the initial base level goes straight into the base level
          REG_INIT_BASE:  base_level <= cfg_data;
          REG_LEVEL_MIN:  level_min <= cfg_data;
          REG_LEVEL_MAX:  level_max <= cfg_data;
        endcase
      end
      if (cmd.load) begin
        last_error <= err;
        if (err_small && last_small) begin
          base_level <= last_level;
        end
      end
      if (cmd.integ_upd) begin
        integral_sum <= integ_next;
      end
      if (cmd.fin) begin
        last_level <= lvl_lo[31:0];
      end
    end
  end

  // Working registers and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r <= err;
      diff_r <= diff;
      integ_en <= err_integ;
      adapted <= err_small && last_small;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.acc_load) begin
      acc <= {prod[58], prod};
    end else if (cmd.acc_add) begin
      acc <= acc + {prod[58], prod};
    end
    if (cmd.rnd) begin
      rnd_r <= acc_rnd[59:24];
    end
    if (cmd.fin) begin
      pwm_level <= lvl_lo[31:0];
      base_adapted <= adapted;
    end
  end

endmodule

FILE: design/altitude_pid_pwm_top.sv
// Altitude PID controller with integral clamp driving one PWM level.
// An accepted height request steps through MDT, MP, MI, MD, SUM, RND and FIN;
//   no new one is taken before it ends. The single shared 26x33 multiplier
//   forms err*dt, then the P, I and D products one after another.
// Reset (rst, synchronous) loads the register defaults, clears the error and
//   integral, and sets the base level to the initial base level.
module altitude_pid_pwm_top
  import altpid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        pwm_level,
  output logic               base_adapted,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  dp_cmd_t cmd;

  // Sequencer
  altpid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Arithmetic and state
  altpid_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .height       (height),
    .pwm_level    (pwm_level),
    .base_adapted (base_adapted)
  );

endmodule
